>>> src/bvm_pkg.sv
package bvm_pkg;

	localparam int unsigned MAX_COMPONENTS = 4096;
	localparam int unsigned COMP_AW        = $clog2(MAX_COMPONENTS);

	localparam logic [1:0] MODE_LOAD   = 2'd0;
	localparam logic [1:0] MODE_SAMPLE = 2'd1;
	localparam logic [1:0] MODE_READ   = 2'd2;

	localparam logic KIND_VERDICT = 1'b0;
	localparam logic KIND_READOUT = 1'b1;

	// register index taken from paddr[2]
	localparam logic REG_EPS = 1'b0;

	localparam logic [30:0] SAT31 = 31'h7FFF_FFFF;

	typedef struct packed {
		logic [1:0]         mode;
		logic [11:0]        component_index;
		logic signed [31:0] value_a;
		logic signed [31:0] value_b;
		logic               last_element;
	} in_item_t;

	typedef struct packed {
		logic        result_kind;
		logic        sample_valid;
		logic [30:0] worst_excess;
		logic [30:0] overall_max_violation;
		logic [31:0] samples_seen;
		logic [31:0] samples_passed;
	} out_item_t;

	typedef struct packed {
		logic               valid;
		logic [COMP_AW-1:0] addr;
		logic [30:0]        data;
	} wr_rec_t;

endpackage

>>> src/bounds_violation_monitor_top.sv
// Accepted beats pass stage 1 and stage 2 before a result enters the output register.
// Throughput: one item per cycle unless a stalled output freezes the pipe. The bound
// and worst-violation tables are synchronous memories; the worst table is read at
// accept and written back from stage 2, forwarding the two most recent write-backs.
// Reset clears counters, running sample state, element position and tolerance;
// table contents are not cleared, so bounds must be loaded before they are checked.
module bounds_violation_monitor_top
	import bvm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [63:0] bnd_mem [MAX_COMPONENTS];
	logic [30:0] worst_mem [MAX_COMPONENTS];
	logic [63:0] bnd_rd_q;
	logic [30:0] worst_rd_q;

	logic [30:0]        eps_q;
	logic [COMP_AW-1:0] pos_q;
	logic [30:0]        run_worst_q;
	logic               run_ok_q;
	logic [30:0]        gmax_q;
	logic [31:0]        total_q;
	logic [31:0]        pass_q;
	logic               out_valid_q;
	out_item_t          out_data_q;
	wr_rec_t            wr_a_q;
	wr_rec_t            wr_b_q;

	logic               valid_s1;
	logic [1:0]         mode_s1;
	logic [COMP_AW-1:0] addr_s1;
	logic signed [31:0] a_s1;
	logic               last_s1;

	logic               valid_s2;
	logic [1:0]         mode_s2;
	logic [COMP_AW-1:0] addr_s2;
	logic               last_s2;
	logic               viol_s2;
	logic [30:0]        sat_s2;
	logic [30:0]        worst_old_s2;

	logic               adv;
	logic               accept;
	logic [COMP_AW-1:0] rd_addr;
	logic               s2_result;

	logic signed [33:0] lo_x, up_x, a_x, eps_x, v_lo, v_hi, v_max;
	logic               viol_s1;
	logic [30:0]        sat_s1;

	logic [30:0] fwd_worst, cmp_worst, run_worst_nx, gmax_nx;
	logic        run_ok_nx;
	logic [31:0] total_nx, pass_nx;
	wr_rec_t     wr_now;
	out_item_t   result;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_EPS) ? {1'b0, eps_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == REG_EPS) begin
			eps_q <= pwdata[30:0];
		end
	end

	// the pipe freezes only when s2 has a result and the output register cannot take it
	assign s2_result = valid_s2 && ((mode_s2 == MODE_SAMPLE && last_s2) || mode_s2 == MODE_READ);
	assign adv       = !(s2_result && out_valid_q && out_stall);
	assign in_stall  = !adv;
	assign accept    = in_valid && adv;
	assign rd_addr   = (in_data.mode == MODE_SAMPLE) ? pos_q : in_data.component_index;

	// bounds memory: written at accept, read at accept
	always_ff @(posedge clk) begin
		if (accept && in_data.mode == MODE_LOAD) begin
			bnd_mem[in_data.component_index] <= {in_data.value_a, in_data.value_b};
		end
		if (adv) begin
			bnd_rd_q <= bnd_mem[pos_q];
		end
	end

	// worst memory: read at accept, written back from s2
	always_ff @(posedge clk) begin
		if (adv && wr_now.valid) begin
			worst_mem[wr_now.addr] <= wr_now.data;
		end
		if (adv) begin
			worst_rd_q <= worst_mem[rd_addr];
		end
	end

	// stage 1: violation arithmetic
	always_comb begin
		lo_x    = {{2{bnd_rd_q[63]}}, bnd_rd_q[63:32]};
		up_x    = {{2{bnd_rd_q[31]}}, bnd_rd_q[31:0]};
		a_x     = {{2{a_s1[31]}}, a_s1};
		eps_x   = {3'b000, eps_q};
		v_lo    = lo_x - a_x - eps_x;
		v_hi    = a_x - up_x - eps_x;
		v_max   = (v_lo > v_hi) ? v_lo : v_hi;
		viol_s1 = v_max > 34'sd0;
		sat_s1  = (v_max > 34'sd2147483647) ? SAT31 : v_max[30:0];
	end

	// stage 2: worst update, running sample state, result
	always_comb begin
		if (wr_a_q.valid && wr_a_q.addr == addr_s2) begin
			fwd_worst = wr_a_q.data;
		end else if (wr_b_q.valid && wr_b_q.addr == addr_s2) begin
			fwd_worst = wr_b_q.data;
		end else begin
			fwd_worst = worst_old_s2;
		end

		cmp_worst    = (viol_s2 && sat_s2 > fwd_worst) ? sat_s2 : fwd_worst;
		run_worst_nx = (viol_s2 && sat_s2 > run_worst_q) ? sat_s2 : run_worst_q;
		gmax_nx      = (viol_s2 && sat_s2 > gmax_q) ? sat_s2 : gmax_q;
		run_ok_nx    = run_ok_q && !viol_s2;
		total_nx     = (&total_q) ? total_q : total_q + 32'd1;
		pass_nx      = (run_ok_nx && !(&pass_q)) ? pass_q + 32'd1 : pass_q;

		wr_now        = '0;
		wr_now.addr   = addr_s2;
		result        = '0;
		result.overall_max_violation = gmax_q;
		result.samples_seen          = total_q;
		result.samples_passed        = pass_q;

		unique case (mode_s2)
			MODE_LOAD: begin
				wr_now.valid = valid_s2;
				wr_now.data  = '0;
			end
			MODE_SAMPLE: begin
				wr_now.valid = valid_s2;
				wr_now.data  = cmp_worst;
				result.result_kind           = KIND_VERDICT;
				result.sample_valid          = run_ok_nx;
				result.worst_excess          = run_worst_nx;
				result.overall_max_violation = gmax_nx;
				result.samples_seen          = total_nx;
				result.samples_passed        = pass_nx;
			end
			MODE_READ: begin
				result.result_kind  = KIND_READOUT;
				result.worst_excess = fwd_worst;
			end
			default: begin
				wr_now.valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			wr_a_q   <= '0;
			wr_b_q   <= '0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			wr_a_q   <= wr_now;
			wr_b_q   <= wr_a_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1      <= in_data.mode;
			addr_s1      <= rd_addr;
			a_s1         <= in_data.value_a;
			last_s1      <= in_data.last_element;
			mode_s2      <= mode_s1;
			addr_s2      <= addr_s1;
			last_s2      <= last_s1;
			viol_s2      <= viol_s1;
			sat_s2       <= sat_s1;
			worst_old_s2 <= worst_rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept && in_data.mode == MODE_SAMPLE) begin
			pos_q <= in_data.last_element ? '0 : pos_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_worst_q <= '0;
			run_ok_q    <= 1'b1;
			gmax_q      <= '0;
			total_q     <= '0;
			pass_q      <= '0;
		end else if (adv && valid_s2 && mode_s2 == MODE_SAMPLE) begin
			gmax_q <= gmax_nx;
			if (last_s2) begin
				run_worst_q <= '0;
				run_ok_q    <= 1'b1;
				total_q     <= total_nx;
				pass_q      <= pass_nx;
			end else begin
				run_worst_q <= run_worst_nx;
				run_ok_q    <= run_ok_nx;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && s2_result) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s2_result) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while output beat is not blocked");

	a_pass_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		pass_q <= total_q)
		else $error("pass count exceeds sample count");

	a_gmax_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> gmax_q >= $past(gmax_q))
		else $error("global max violation decreased");

	a_pos_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_data.mode == MODE_SAMPLE && in_data.last_element) |=> pos_q == '0)
		else $error("element position did not restart after last element");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top
	import bvm_pkg::*;
();

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam longint     S32_MIN     = -64'sd2147483648;
	localparam longint     S32_MAX     = 64'sd2147483647;
	localparam longint     Q_ONE       = 64'sd65536;
	// components that vectors stay within and that unloaded readouts fall back to
	localparam int         N_LIVE      = 48;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_data  = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_data;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	bounds_violation_monitor_top uut (.*);

	// shadow state of the monitor
	logic signed [31:0] bound_lo [MAX_COMPONENTS];
	logic signed [31:0] bound_hi [MAX_COMPONENTS];
	logic [30:0]        comp_worst [MAX_COMPONENTS];
	bit                 bound_set [MAX_COMPONENTS];
	logic [COMP_AW-1:0] elem_pos  = '0;
	logic [30:0]        vec_worst = '0;
	logic               vec_ok    = 1'b1;
	logic [30:0]        peak_viol = '0;
	logic [31:0]        seen_cnt  = '0;
	logic [31:0]        pass_cnt  = '0;
	logic [30:0]        eps_val   = '0;
	out_item_t          due_reports [$];

	int errors     = 0;
	int n_items    = 0;
	int n_verdicts = 0;
	int n_failed   = 0;
	int n_readouts = 0;
	int idle_pct   = 0;
	int stall_pct  = 0;
	int stall_left = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

	function automatic int unsigned gap_len();
		return ($urandom_range(9) == 0) ? $urandom_range(24, 6) : $urandom_range(3, 1);
	endfunction

	function automatic int pct_pick();
		case ($urandom_range(2))
			0: return 0;
			1: return 15;
			default: return 50;
		endcase
	endfunction

	function automatic longint clamp32(longint v);
		if (v < S32_MIN) return S32_MIN;
		if (v > S32_MAX) return S32_MAX;
		return v;
	endfunction

	function automatic int field_diff(string name, logic [31:0] exp_v, logic [31:0] got_v);
		if (got_v === exp_v) return 0;
		$display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, exp_v, got_v);
		return 1;
	endfunction

	// update shadow state for one accepted beat, queue the report it causes
	function automatic void score_item(in_item_t it);
		longint             lo_gap;
		longint             hi_gap;
		longint             viol;
		logic [30:0]        amt;
		logic [COMP_AW-1:0] idx;
		idx = it.component_index;
		case (it.mode)
			MODE_LOAD: begin
				bound_lo[idx]   = it.value_a;
				bound_hi[idx]   = it.value_b;
				comp_worst[idx] = '0;
				bound_set[idx]  = 1'b1;
			end
			MODE_READ: begin
				due_reports.push_back('{KIND_READOUT, 1'b0, comp_worst[idx], peak_viol,
					seen_cnt, pass_cnt});
			end
			MODE_SAMPLE: begin
				lo_gap = longint'(bound_lo[elem_pos]) - longint'($signed(it.value_a))
					- longint'(eps_val);
				hi_gap = longint'($signed(it.value_a)) - longint'(bound_hi[elem_pos])
					- longint'(eps_val);
				viol = (lo_gap > hi_gap) ? lo_gap : hi_gap;
				if (viol > 0) begin
					amt = (viol > longint'(SAT31)) ? SAT31 : viol[30:0];
					vec_ok = 1'b0;
					if (amt > peak_viol) peak_viol = amt;
					if (amt > comp_worst[elem_pos]) comp_worst[elem_pos] = amt;
					if (amt > vec_worst) vec_worst = amt;
				end
				elem_pos = elem_pos + 1'b1;
				if (it.last_element) begin
					if (seen_cnt != '1) seen_cnt++;
					if (vec_ok && pass_cnt != '1) pass_cnt++;
					due_reports.push_back('{KIND_VERDICT, vec_ok, vec_worst, peak_viol,
						seen_cnt, pass_cnt});
					elem_pos  = '0;
					vec_worst = '0;
					vec_ok    = 1'b1;
				end
			end
			default: ;
		endcase
	endfunction

	task automatic send_item(input logic [1:0] m, input logic [11:0] idx, input longint a,
			input longint b, input logic last);
		in_item_t    it;
		int unsigned gap;
		it = '{m, idx, a[31:0], b[31:0], last};
		gap = ($urandom_range(99) < idle_pct) ? gap_len() : 0;
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
		score_item(it);
		if (m != MODE_UNUSED) n_items++;
	endtask

	// drop valid, wait for every report, then let the pipeline empty
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (due_reports.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// write tolerance, then read it back in the next transfer
	task automatic set_eps(input logic [31:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_EPS, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		eps_val = val[30:0];
		@(negedge clk);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		errors += field_diff("tolerance_eps readback", {1'b0, eps_val}, prdata);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (stall_left == 0 && $urandom_range(99) < stall_pct) stall_left = gap_len();
		out_stall <= (stall_left != 0);
		if (stall_left != 0) stall_left--;
	end

	always @(posedge clk) begin : result_check
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (due_reports.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got %p", $time, out_data);
			end else begin
				want = due_reports.pop_front();
				errors += field_diff("result_kind", 32'(want.result_kind),
					32'(out_data.result_kind));
				errors += field_diff("sample_valid", 32'(want.sample_valid),
					32'(out_data.sample_valid));
				errors += field_diff("worst_excess", 32'(want.worst_excess),
					32'(out_data.worst_excess));
				errors += field_diff("overall_max_violation", 32'(want.overall_max_violation),
					32'(out_data.overall_max_violation));
				errors += field_diff("samples_seen", want.samples_seen, out_data.samples_seen);
				errors += field_diff("samples_passed", want.samples_passed,
					out_data.samples_passed);
				if (want.result_kind == KIND_READOUT) begin
					n_readouts++;
				end else begin
					n_verdicts++;
					if (!want.sample_valid) n_failed++;
				end
			end
		end
	end

	task automatic test_tolerance_register();
		set_eps(32'h7FFF_FFFF);
		set_eps(32'hFFFF_FFFF);
		set_eps(32'h0000_0001);
		set_eps(32'h0000_0000);
	endtask

	// open bounds on every component that is later sampled or read back
	task automatic test_load_all();
		idle_pct  = 5;
		stall_pct = 5;
		for (int i = 0; i < N_LIVE; i++)
			send_item(MODE_LOAD, i[11:0], S32_MIN, S32_MAX, 1'($urandom_range(1)));
		send_item(MODE_LOAD, 12'hFFF, S32_MIN, S32_MAX, 1'b0);
		settle();
	endtask

	task automatic test_directed_cases();
		idle_pct  = 20;
		stall_pct = 20;
		send_item(MODE_LOAD, 12'd0, -Q_ONE, Q_ONE, 1'b0);
		send_item(MODE_LOAD, 12'd1, S32_MAX, S32_MAX, 1'b0);
		send_item(MODE_LOAD, 12'd2, 64'sd10, -64'sd10, 1'b0);  // crossed bounds
		send_item(MODE_SAMPLE, 12'd0, -Q_ONE, 0, 1'b1);        // exactly on lower
		send_item(MODE_SAMPLE, 12'd0, Q_ONE, 0, 1'b1);         // exactly on upper
		send_item(MODE_SAMPLE, 12'd0, Q_ONE + 1, 0, 1'b0);     // one lsb over
		send_item(MODE_SAMPLE, 12'd0, S32_MIN, 0, 1'b0);       // saturates
		send_item(MODE_SAMPLE, 12'd0, 0, 0, 1'b1);
		send_item(MODE_READ, 12'd0, 0, 0, 1'b0);
		send_item(MODE_READ, 12'd1, 0, 0, 1'b0);
		send_item(MODE_READ, 12'd2, 0, 0, 1'b0);
		send_item(MODE_UNUSED, 12'hFFF, S32_MIN, S32_MAX, 1'b1);
		send_item(MODE_LOAD, 12'd0, -Q_ONE, Q_ONE, 1'b0);      // reload clears worst
		send_item(MODE_READ, 12'd0, 0, 0, 1'b0);
		send_item(MODE_LOAD, 12'd1, S32_MIN, S32_MIN, 1'b0);
		send_item(MODE_SAMPLE, 12'd0, 0, 0, 1'b0);
		send_item(MODE_SAMPLE, 12'd0, S32_MAX, 0, 1'b1);       // saturates high side
		send_item(MODE_READ, 12'hFFF, 0, 0, 1'b0);
		settle();
		set_eps(32'hFFFF_FFFF);
		send_item(MODE_SAMPLE, 12'd0, S32_MAX, 0, 1'b0);
		send_item(MODE_SAMPLE, 12'd0, S32_MAX, 0, 1'b1);       // still over max slack
		send_item(MODE_SAMPLE, 12'd0, Q_ONE + 5, 0, 1'b1);     // slack absorbs it
		send_item(MODE_READ, 12'd1, 0, 0, 1'b0);
		settle();
	endtask

	task automatic test_random_traffic();
		logic [31:0] eps_plan [5];
		longint      lo;
		longint      hi;
		longint      x;
		longint      span;
		longint      off;
		int unsigned len;
		int unsigned quota;
		int unsigned sent;
		int unsigned pick;
		logic [11:0] idx;
		eps_plan[0] = 32'h0;
		eps_plan[1] = $urandom_range(32'h0002_0000, 1);
		eps_plan[2] = $urandom;
		eps_plan[3] = 32'h7FFF_FFFF;
		eps_plan[4] = $urandom_range(255, 1);
		for (int p = 0; p < 5; p++) begin
			settle();
			set_eps(eps_plan[p]);
			quota = (p == 3) ? 60 : 230;
			sent  = 0;
			while (sent < quota) begin
				if ($urandom_range(49) == 0) begin
					idle_pct  = pct_pick();
					stall_pct = pct_pick();
				end
				pick = $urandom_range(99);
				idx  = $urandom_range(1) ? 12'($urandom_range(N_LIVE - 1)) : 12'($urandom);
				if (pick < 62) begin
					len = ($urandom_range(7) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
					for (int k = 0; k < len; k++) begin
						// noise inside an open vector
						if ($urandom_range(29) == 0)
							send_item($urandom_range(1) ? MODE_READ : MODE_UNUSED,
								12'($urandom_range(N_LIVE - 1)), $urandom, $urandom,
								1'($urandom));
						lo  = bound_lo[elem_pos];
						hi  = bound_hi[elem_pos];
						off = longint'($urandom_range(131072)) - 64'sd65536;
						case ($urandom_range(19))
							0: x = lo - longint'(eps_val) - off;
							1: x = hi + longint'(eps_val) + off;
							2: x = longint'($signed($urandom));
							default: begin
								if (hi >= lo) begin
									span = hi - lo + 1;
									x = lo + longint'({$urandom, $urandom} % span);
								end else begin
									x = lo + off;
								end
							end
						endcase
						send_item(MODE_SAMPLE, 12'($urandom), clamp32(x), $urandom,
							k == len - 1);
					end
					sent += len;
				end else if (pick < 80) begin
					case ($urandom_range(9))
						0: begin
							lo = longint'($signed($urandom));
							hi = longint'($signed($urandom));
						end
						1: begin
							lo = S32_MIN;
							hi = S32_MAX;
						end
						default: begin
							lo = longint'($signed($urandom)) >>> 4;
							hi = lo + $urandom_range(32'h0004_0000);
						end
					endcase
					send_item(MODE_LOAD, idx, lo, clamp32(hi), 1'($urandom));
					sent++;
				end else if (pick < 95) begin
					if (!bound_set[idx]) idx = 12'($urandom_range(N_LIVE - 1));
					send_item(MODE_READ, idx, $urandom, $urandom, 1'($urandom));
					sent++;
				end else begin
					send_item(MODE_UNUSED, idx, $urandom, $urandom, 1'($urandom));
				end
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_tolerance_register();
		test_load_all();
		test_directed_cases();
		test_random_traffic();
		settle();
		$display("Ran %0d beats: bound loads, edge cases, random traffic over 5 tolerances;",
			n_items);
		$display("%0d verdicts (%0d failing), %0d readouts.",
			n_verdicts, n_failed, n_readouts);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
